@@ rtl/gtp_pkg.sv @@
// ----------------------------------------------------------------------------
// gtp_pkg
// shared constants for the generalized time parser: status codes, character
// codes, field widths, field positions and range limits
// ----------------------------------------------------------------------------
package gtp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned StatusW = 4;
  localparam int unsigned YearW   = 14;
  localparam int unsigned AccW    = 7;
  localparam int unsigned PosW    = 5;

  localparam logic [StatusW-1:0] StOk       = 4'd0;
  localparam logic [StatusW-1:0] StShort    = 4'd1;
  localparam logic [StatusW-1:0] StNoZ      = 4'd2;
  localparam logic [StatusW-1:0] StNondigit = 4'd3;
  localparam logic [StatusW-1:0] StMonth    = 4'd4;
  localparam logic [StatusW-1:0] StDay      = 4'd5;
  localparam logic [StatusW-1:0] StHour     = 4'd6;
  localparam logic [StatusW-1:0] StMinute   = 4'd7;
  localparam logic [StatusW-1:0] StSecond   = 4'd8;

  localparam logic [CharW-1:0] CharZero = 8'h30;
  localparam logic [CharW-1:0] CharNine = 8'h39;
  localparam logic [CharW-1:0] CharZ    = 8'h5a;

  localparam logic [YearW-1:0] YearBase = 14'd1900;

  localparam logic [PosW-1:0] PosMonth  = 5'd4;
  localparam logic [PosW-1:0] PosDay    = 5'd6;
  localparam logic [PosW-1:0] PosHour   = 5'd8;
  localparam logic [PosW-1:0] PosMinute = 5'd10;
  localparam logic [PosW-1:0] PosSecond = 5'd12;
  localparam logic [PosW-1:0] PosSecEnd = 5'd14;
  localparam logic [PosW-1:0] PosSecLo  = 5'd13;
  localparam logic [PosW-1:0] PosMinLen = 5'd11;
  localparam logic [PosW-1:0] PosMax    = 5'd31;

  localparam logic [AccW-1:0] MonthMax  = 7'd12;
  localparam logic [AccW-1:0] DayMax    = 7'd31;
  localparam logic [AccW-1:0] HourMax   = 7'd23;
  localparam logic [AccW-1:0] MinSecMax = 7'd59;

endpackage

@@ rtl/generalized_time_parser_unit.sv @@
// ----------------------------------------------------------------------------
// generalized_time_parser_unit
// parses a gmt timestamp text one character word at a time and gives one
// result word with status and broken-down time on the final character
// ----------------------------------------------------------------------------
// the result word for a final character passes through the input register,
// then the result register, before it is valid
// throughput: one character word per cycle, held back only by out_ready
// reset: clears both valid flags, the position count, flags and accumulators
// ----------------------------------------------------------------------------
module generalized_time_parser_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gtp_pkg::CharW-1:0]         char_code,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gtp_pkg::StatusW-1:0]       status,
  output logic signed [gtp_pkg::YearW-1:0]  year_since_1900,
  output logic [3:0]                        month_index,
  output logic [4:0]                        day_of_month,
  output logic [4:0]                        hour_value,
  output logic [5:0]                        minute_value,
  output logic [5:0]                        second_value
);

  // input register
  logic                      hold_valid;
  logic [gtp_pkg::CharW-1:0] hold_char;
  logic                      hold_last;

  // parse state
  logic [gtp_pkg::PosW-1:0]  position_count;
  logic                      nondigit_seen;
  logic [gtp_pkg::YearW-1:0] year_acc;
  logic [gtp_pkg::AccW-1:0]  month_acc;
  logic [gtp_pkg::AccW-1:0]  day_acc;
  logic [gtp_pkg::AccW-1:0]  hour_acc;
  logic [gtp_pkg::AccW-1:0]  minute_acc;
  logic [gtp_pkg::AccW-1:0]  second_acc;
  logic                      second_digits_ok;

  logic                      advance;
  logic                      step;
  logic                      is_digit;
  logic [3:0]                digit;
  logic [gtp_pkg::YearW-1:0] year_next;
  logic [gtp_pkg::AccW-1:0]  month_next;
  logic [gtp_pkg::AccW-1:0]  day_next;
  logic [gtp_pkg::AccW-1:0]  hour_next;
  logic [gtp_pkg::AccW-1:0]  minute_next;
  logic [gtp_pkg::AccW-1:0]  second_next;
  logic [gtp_pkg::StatusW-1:0] status_next;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !hold_valid || advance;
  assign step     = hold_valid && advance;

  assign is_digit = (hold_char >= gtp_pkg::CharZero) && (hold_char <= gtp_pkg::CharNine);
  assign digit    = is_digit ? hold_char[3:0] : 4'd0;

  // times ten plus digit, wrapping at the accumulator width
  assign year_next   = {year_acc[gtp_pkg::YearW-4:0], 3'b000}
                     + {year_acc[gtp_pkg::YearW-2:0], 1'b0}
                     + {{(gtp_pkg::YearW-4){1'b0}}, digit};
  assign month_next  = {month_acc[gtp_pkg::AccW-4:0], 3'b000}
                     + {month_acc[gtp_pkg::AccW-2:0], 1'b0} + {3'b000, digit};
  assign day_next    = {day_acc[gtp_pkg::AccW-4:0], 3'b000}
                     + {day_acc[gtp_pkg::AccW-2:0], 1'b0} + {3'b000, digit};
  assign hour_next   = {hour_acc[gtp_pkg::AccW-4:0], 3'b000}
                     + {hour_acc[gtp_pkg::AccW-2:0], 1'b0} + {3'b000, digit};
  assign minute_next = {minute_acc[gtp_pkg::AccW-4:0], 3'b000}
                     + {minute_acc[gtp_pkg::AccW-2:0], 1'b0} + {3'b000, digit};
  assign second_next = {second_acc[gtp_pkg::AccW-4:0], 3'b000}
                     + {second_acc[gtp_pkg::AccW-2:0], 1'b0} + {3'b000, digit};

  always_comb begin
    if (position_count < gtp_pkg::PosMinLen) begin
      status_next = gtp_pkg::StShort;
    end else if (hold_char != gtp_pkg::CharZ) begin
      status_next = gtp_pkg::StNoZ;
    end else if (nondigit_seen) begin
      status_next = gtp_pkg::StNondigit;
    end else if (month_acc == '0 || month_acc > gtp_pkg::MonthMax) begin
      status_next = gtp_pkg::StMonth;
    end else if (day_acc == '0 || day_acc > gtp_pkg::DayMax) begin
      status_next = gtp_pkg::StDay;
    end else if (hour_acc > gtp_pkg::HourMax) begin
      status_next = gtp_pkg::StHour;
    end else if (position_count == gtp_pkg::PosMinLen || minute_acc > gtp_pkg::MinSecMax) begin
      status_next = gtp_pkg::StMinute;
    end else if (second_digits_ok && second_acc > gtp_pkg::MinSecMax) begin
      status_next = gtp_pkg::StSecond;
    end else begin
      status_next = gtp_pkg::StOk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      hold_char <= char_code;
      hold_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count   <= '0;
      nondigit_seen    <= 1'b0;
      year_acc         <= '0;
      month_acc        <= '0;
      day_acc          <= '0;
      hour_acc         <= '0;
      minute_acc       <= '0;
      second_acc       <= '0;
      second_digits_ok <= 1'b0;
    end else if (step) begin
      if (hold_last) begin
        position_count   <= '0;
        nondigit_seen    <= 1'b0;
        year_acc         <= '0;
        month_acc        <= '0;
        day_acc          <= '0;
        hour_acc         <= '0;
        minute_acc       <= '0;
        second_acc       <= '0;
        second_digits_ok <= 1'b0;
      end else begin
        if (!is_digit) begin
          nondigit_seen <= 1'b1;
        end else if (position_count < gtp_pkg::PosMonth) begin
          year_acc <= year_next;
        end else if (position_count < gtp_pkg::PosDay) begin
          month_acc <= month_next;
        end else if (position_count < gtp_pkg::PosHour) begin
          day_acc <= day_next;
        end else if (position_count < gtp_pkg::PosMinute) begin
          hour_acc <= hour_next;
        end else if (position_count < gtp_pkg::PosSecond) begin
          minute_acc <= minute_next;
        end else if (position_count < gtp_pkg::PosSecEnd) begin
          second_acc <= second_next;
          if (position_count == gtp_pkg::PosSecLo) begin
            second_digits_ok <= 1'b1;
          end
        end
        if (position_count != gtp_pkg::PosMax) begin
          position_count <= position_count + 5'd1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && hold_last;
    end
    if (step && hold_last) begin
      status <= status_next;
      if (status_next == gtp_pkg::StOk) begin
        year_since_1900 <= year_acc - gtp_pkg::YearBase;
        month_index     <= month_acc[3:0] - 4'd1;
        day_of_month    <= day_acc[4:0];
        hour_value      <= hour_acc[4:0];
        minute_value    <= minute_acc[5:0];
        second_value    <= second_digits_ok ? second_acc[5:0] : 6'd0;
      end else begin
        year_since_1900 <= '0;
        month_index     <= '0;
        day_of_month    <= '0;
        hour_value      <= '0;
        minute_value    <= '0;
        second_value    <= '0;
      end
    end
  end

endmodule
